>>> rtl/brlt_pkg.sv
// Shared types and constants of the byte-range lock table.
package brlt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam logic [63:0] END_OF_FILE = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam logic [1:0] KIND_SHARED = 2'd0;
	localparam logic [1:0] KIND_EXCL   = 2'd1;

	typedef enum logic [1:0] {
		OP_ACQUIRE     = 2'd0,
		OP_RELEASE     = 2'd1,
		OP_CHECK       = 2'd2,
		OP_RELEASE_ALL = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_DENIED    = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_KIND  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_END,
		S_SCAN,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic file_eq;
		logic owner_eq;
		logic span_hit;
	} match_t;

endpackage

>>> rtl/byte_range_lock_table.sv
// Top level of the byte-range lock table: sequencer, entry storage and result register.
//
// An item is taken when start is high and busy is low; busy stays high until the
// sequencer has finished, and the status appears with a one-cycle done strobe that
// cannot be held off. All work runs through one compare unit that visits one table
// entry per cycle, so the scan of the TABLE_ENTRIES entries sets the latency. An
// acquire first forms the saturated region end in the sum and end states, then
// scans, commits and shows the strobe; release, release-all and check go straight
// to the scan, and an acquire with an invalid kind goes straight to the commit.
// busy drops in the cycle the strobe shows, so the next item may be taken there.
// Region ends are stored precomputed and saturate at all ones.
module byte_range_lock_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] owner_id,
	input  logic [31:0] file_id,
	input  logic [1:0]  lock_kind,
	input  logic [63:0] region_start,
	input  logic [63:0] region_length,
	input  logic [63:0] probe_offset,
	input  logic        is_write,
	output logic        done,
	output logic [2:0]  status
);
	import brlt_pkg::*;

	state_t                 state_q, state_d;
	logic [IDX_W-1:0]       idx_q;
	opcode_t                op_q;
	logic [31:0]            owner_q, file_q;
	logic                   excl_q, write_q, bad_q;
	logic [63:0]            start_q, len_q;
	logic [64:0]            sum_q;
	logic [63:0]            key_hi_q, key_lo_q;
	logic                   conflict_q;
	logic [TABLE_ENTRIES-1:0] drop_q;
	logic                   free_found_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
	status_t                status_q, status_d;
	logic                   done_q;

	logic [31:0] ent_owner_q [TABLE_ENTRIES];
	logic [31:0] ent_file_q  [TABLE_ENTRIES];
	logic        ent_excl_q  [TABLE_ENTRIES];
	logic [63:0] ent_start_q [TABLE_ENTRIES];
	logic [63:0] ent_end_q   [TABLE_ENTRIES];

	match_t m;
	logic   accept, last, ent_v, own, hit_deny, ins_en, sat;

	brlt_cmp u_cmp (
		.ent_owner (ent_owner_q[idx_q]),
		.ent_file  (ent_file_q[idx_q]),
		.ent_start (ent_start_q[idx_q]),
		.ent_end   (ent_end_q[idx_q]),
		.req_owner (owner_q),
		.req_file  (file_q),
		.key_hi    (key_hi_q),
		.key_lo    (key_lo_q),
		.match     (m)
	);

	assign accept = start && (state_q == S_IDLE);
	assign last   = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
	assign ent_v  = valid_q[idx_q];
	assign own    = ent_v && m.owner_eq && ((op_q == OP_RELEASE_ALL) || m.file_eq);
	assign sat    = (len_q == 64'd0) || (sum_q[64] && (sum_q[63:0] != 64'd0));

	// Deny rule differs: acquire skips own locks and needs an exclusive side,
	// check counts every owner and denies any write inside a lock or any access inside an exclusive one.
	always_comb begin
		if (op_q == OP_ACQUIRE) begin
			hit_deny = ent_v && m.file_eq && m.span_hit && !m.owner_eq &&
				(ent_excl_q[idx_q] || excl_q);
		end else begin
			hit_deny = ent_v && m.file_eq && m.span_hit &&
				(ent_excl_q[idx_q] || write_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		status_d = ST_OK;
		valid_d  = valid_q;
		ins_en   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (opcode_t'(opcode) == OP_ACQUIRE && lock_kind > KIND_EXCL) begin
						state_d = S_COMMIT;
					end else if (opcode_t'(opcode) == OP_ACQUIRE) begin
						state_d = S_SUM;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SUM: begin
				state_d = S_END;
			end
			S_END: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (last) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				state_d = S_IDLE;
				if (bad_q) begin
					status_d = ST_BAD_KIND;
				end else begin
					unique case (op_q)
						OP_ACQUIRE: begin
							if (conflict_q) begin
								status_d = ST_DENIED;
							end else begin
								valid_d = valid_q & ~drop_q;
								if (free_found_q) begin
									valid_d[free_idx_q] = 1'b1;
									ins_en = 1'b1;
								end else begin
									status_d = ST_FULL;
								end
							end
						end
						OP_RELEASE: begin
							valid_d  = valid_q & ~drop_q;
							status_d = (drop_q != '0) ? ST_OK : ST_NOT_FOUND;
						end
						OP_CHECK: begin
							status_d = conflict_q ? ST_DENIED : ST_OK;
						end
						OP_RELEASE_ALL: begin
							valid_d = valid_q & ~drop_q;
						end
						default: begin
							status_d = ST_OK;
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Request capture and scan bookkeeping.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q         <= opcode_t'(opcode);
					owner_q      <= owner_id;
					file_q       <= file_id;
					excl_q       <= (lock_kind == KIND_EXCL);
					bad_q        <= (opcode_t'(opcode) == OP_ACQUIRE) && (lock_kind > KIND_EXCL);
					write_q      <= is_write;
					start_q      <= region_start;
					len_q        <= region_length;
					key_hi_q     <= probe_offset;
					key_lo_q     <= probe_offset;
					idx_q        <= '0;
					conflict_q   <= 1'b0;
					drop_q       <= '0;
					free_found_q <= 1'b0;
					free_idx_q   <= '0;
				end
			end
			S_SUM: begin
				sum_q    <= {1'b0, start_q} + {1'b0, len_q};
				key_lo_q <= start_q;
			end
			S_END: begin
				key_hi_q <= sat ? END_OF_FILE : (sum_q[63:0] - 64'd1);
			end
			S_SCAN: begin
				drop_q[idx_q] <= own;
				if (hit_deny) begin
					conflict_q <= 1'b1;
				end
				// Lowest slot that is free once the caller's own locks are dropped.
				if (!free_found_q && (!ent_v || own)) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_q;
				end
				idx_q <= idx_q + IDX_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			valid_q <= valid_d;
			done_q  <= (state_q == S_COMMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_COMMIT) begin
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en) begin
			ent_owner_q[free_idx_q] <= owner_q;
			ent_file_q[free_idx_q]  <= file_q;
			ent_excl_q[free_idx_q]  <= excl_q;
			ent_start_q[free_idx_q] <= start_q;
			ent_end_q[free_idx_q]   <= key_hi_q;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;

endmodule

>>> rtl/brlt_cmp.sv
// Shared compare unit: matches one table entry against the request held in the sequencer.
module brlt_cmp (
	input  logic [31:0]     ent_owner,
	input  logic [31:0]     ent_file,
	input  logic [63:0]     ent_start,
	input  logic [63:0]     ent_end,
	input  logic [31:0]     req_owner,
	input  logic [31:0]     req_file,
	input  logic [63:0]     key_hi,
	input  logic [63:0]     key_lo,
	output brlt_pkg::match_t match
);
	import brlt_pkg::*;

	// Span hit: entry starts at or below key_hi and ends at or above key_lo.
	always_comb begin
		match.file_eq  = (ent_file == req_file);
		match.owner_eq = (ent_owner == req_owner);
		match.span_hit = (ent_start <= key_hi) && (key_lo <= ent_end);
	end

endmodule

>>> rtl/brlt_chk.sv
// Port-level checker for the byte-range lock table and its bind.
module brlt_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [2:0] status
);
	import brlt_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_finish_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= 3'(ST_BAD_KIND)))
		else $error("status code out of range");

endmodule

bind byte_range_lock_table brlt_chk u_brlt_chk (.*);

>>> bench/tb_byte_range_lock_table.sv
// Testbench for byte_range_lock_table: directed table plus random lock traffic, scoreboarded.
`timescale 1ns / 1ps

module tb_byte_range_lock_table;
	import brlt_pkg::*;

	localparam logic [1:0] KIND_BAD_LO = 2'd2;
	localparam logic [1:0] KIND_BAD_HI = 2'd3;
	localparam int RANDOM_ITEMS = 1000;
	localparam int OWNER_POOL = 6;
	localparam int FILE_POOL = 3;

	typedef struct {
		opcode_t     op;
		logic [31:0] owner;
		logic [31:0] file;
		logic [1:0]  kind;
		logic [63:0] rstart;
		logic [63:0] rlen;
		logic [63:0] probe;
		logic        wr;
	} lock_req_t;

	typedef struct {
		lock_req_t req;
		bit        typed;
		status_t   want;
	} lock_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	opcode_t     opcode;
	logic [31:0] owner_id;
	logic [31:0] file_id;
	logic [1:0]  lock_kind;
	logic [63:0] region_start;
	logic [63:0] region_length;
	logic [63:0] probe_offset;
	logic        is_write;
	logic        done;
	logic [2:0]  status;

	// Shadow lock table
	logic        held_valid [TABLE_ENTRIES];
	logic [31:0] held_owner [TABLE_ENTRIES];
	logic [31:0] held_file  [TABLE_ENTRIES];
	logic        held_excl  [TABLE_ENTRIES];
	logic [63:0] held_start [TABLE_ENTRIES];
	logic [63:0] held_len   [TABLE_ENTRIES];

	status_t     due_status [$];
	status_t     oldest_status;
	logic [31:0] owner_pool [OWNER_POOL];
	logic [31:0] file_pool  [FILE_POOL];
	int          errors = 0;
	int          items_sent = 0;
	int          burst_left = 0;

	byte_range_lock_table DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.owner_id     (owner_id),
		.file_id      (file_id),
		.lock_kind    (lock_kind),
		.region_start (region_start),
		.region_length(region_length),
		.probe_offset (probe_offset),
		.is_write     (is_write),
		.done         (done),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_byte_range_lock_table: done, errors");
		$finish;
	end

	// Last byte of a region, saturated at all ones
	function automatic logic [63:0] span_last(logic [63:0] s, logic [63:0] l);
		if (l == 64'd0)
			return END_OF_FILE;
		if (s > END_OF_FILE - (l - 64'd1))
			return END_OF_FILE;
		return s + (l - 64'd1);
	endfunction

	function automatic status_t apply_lock_request(lock_req_t r);
		status_t st;
		logic    excl;
		logic    hit;
		int      slot;
		st = ST_OK;
		hit = 1'b0;
		slot = -1;
		case (r.op)
		OP_ACQUIRE: begin
			if (r.kind != KIND_SHARED && r.kind != KIND_EXCL) begin
				st = ST_BAD_KIND;
			end else begin
				excl = (r.kind == KIND_EXCL);
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (held_valid[i] && held_file[i] == r.file && held_owner[i] != r.owner &&
					    held_start[i] <= span_last(r.rstart, r.rlen) &&
					    r.rstart <= span_last(held_start[i], held_len[i]) &&
					    (held_excl[i] || excl))
						st = ST_DENIED;
				if (st == ST_OK) begin
					for (int i = 0; i < TABLE_ENTRIES; i++)
						if (held_valid[i] && held_owner[i] == r.owner && held_file[i] == r.file)
							held_valid[i] = 1'b0;
					for (int i = 0; i < TABLE_ENTRIES; i++)
						if (!held_valid[i] && slot < 0)
							slot = i;
					if (slot < 0) begin
						st = ST_FULL;
					end else begin
						held_valid[slot] = 1'b1;
						held_owner[slot] = r.owner;
						held_file[slot] = r.file;
						held_excl[slot] = excl;
						held_start[slot] = r.rstart;
						held_len[slot] = r.rlen;
					end
				end
			end
		end
		OP_RELEASE: begin
			for (int i = 0; i < TABLE_ENTRIES; i++)
				if (held_valid[i] && held_owner[i] == r.owner && held_file[i] == r.file) begin
					held_valid[i] = 1'b0;
					hit = 1'b1;
				end
			st = hit ? ST_OK : ST_NOT_FOUND;
		end
		OP_CHECK: begin
			for (int i = 0; i < TABLE_ENTRIES; i++)
				if (held_valid[i] && held_file[i] == r.file && r.probe >= held_start[i] &&
				    r.probe <= span_last(held_start[i], held_len[i]) && (held_excl[i] || r.wr))
					st = ST_DENIED;
		end
		default: begin
			for (int i = 0; i < TABLE_ENTRIES; i++)
				if (held_valid[i] && held_owner[i] == r.owner)
					held_valid[i] = 1'b0;
		end
		endcase
		return st;
	endfunction

	function automatic lock_row_t row(opcode_t op, logic [31:0] own, logic [31:0] fil,
	                                  logic [1:0] kind, logic [63:0] rs, logic [63:0] rl,
	                                  logic [63:0] off, logic wr, bit typed, status_t want);
		lock_row_t x;
		x.req.op = op;
		x.req.owner = own;
		x.req.file = fil;
		x.req.kind = kind;
		x.req.rstart = rs;
		x.req.rlen = rl;
		x.req.probe = off;
		x.req.wr = wr;
		x.typed = typed;
		x.want = want;
		return x;
	endfunction

	// Mostly small offsets so regions meet, with a tail at the extremes
	function automatic logic [63:0] pick_offset();
		case ($urandom_range(0, 9))
		6: return {$urandom, $urandom};
		7: return END_OF_FILE - 64'($urandom_range(0, 15));
		8: return 64'd0;
		9: return 64'($urandom_range(0, 255));
		default: return 64'($urandom_range(0, 63));
		endcase
	endfunction

	function automatic logic [63:0] pick_length();
		case ($urandom_range(0, 9))
		0, 1: return 64'd0;
		7: return {$urandom, $urandom};
		8: return END_OF_FILE;
		9: return 64'($urandom_range(1, 64));
		default: return 64'($urandom_range(1, 16));
		endcase
	endfunction

	function automatic lock_req_t random_request();
		lock_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			r.op = OP_ACQUIRE;
		else if (pick < 75)
			r.op = OP_CHECK;
		else if (pick < 90)
			r.op = OP_RELEASE;
		else
			r.op = OP_RELEASE_ALL;
		r.owner = ($urandom_range(0, 9) == 0) ? $urandom : owner_pool[$urandom_range(0, OWNER_POOL - 1)];
		r.file = ($urandom_range(0, 9) == 0) ? $urandom : file_pool[$urandom_range(0, FILE_POOL - 1)];
		pick = $urandom_range(0, 99);
		if (pick < 70)
			r.kind = KIND_SHARED;
		else if (pick < 95)
			r.kind = KIND_EXCL;
		else if (pick < 98)
			r.kind = KIND_BAD_LO;
		else
			r.kind = KIND_BAD_HI;
		r.rstart = pick_offset();
		r.rlen = pick_length();
		r.probe = pick_offset();
		r.wr = 1'($urandom_range(0, 1));
		return r;
	endfunction

	task automatic issue(input lock_req_t r, input bit typed, input status_t want);
		status_t st;
		int gap;
		@(negedge clk);
		opcode <= r.op;
		owner_id <= r.owner;
		file_id <= r.file;
		lock_kind <= r.kind;
		region_start <= r.rstart;
		region_length <= r.rlen;
		probe_offset <= r.probe;
		is_write <= r.wr;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		st = apply_lock_request(r);
		due_status.push_back(typed ? want : st);
		items_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				@(negedge clk) start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// Hold off until every item has answered
	task automatic settle();
		@(negedge clk) start <= 1'b0;
		while (due_status.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_status.size() == 0) begin
				$error("status: expected nothing, actual %0d", status);
				errors++;
			end else begin
				oldest_status = due_status.pop_front();
				if (status !== oldest_status) begin
					$error("status: expected %0d, actual %0d", oldest_status, status);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		lock_row_t   plan [$];
		lock_req_t   req;
		logic [31:0] fill_owners [$];
		logic [31:0] fill_file;
		int          fill_count;
		bit          paused;
		paused = 1'b0;
		arst_n <= 1'b0;
		start <= 1'b0;
		opcode <= OP_ACQUIRE;
		owner_id <= '0;
		file_id <= '0;
		lock_kind <= KIND_SHARED;
		region_start <= '0;
		region_length <= '0;
		probe_offset <= '0;
		is_write <= 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			held_valid[i] = 1'b0;
			held_owner[i] = '0;
			held_file[i] = '0;
			held_excl[i] = 1'b0;
			held_start[i] = '0;
			held_len[i] = '0;
		end

		plan.push_back(row(OP_CHECK, 32'd0, 32'd0, KIND_SHARED, 64'd0, 64'd0, END_OF_FILE, 1'b1,
		                   1'b1, ST_OK));
		plan.push_back(row(OP_RELEASE, 32'd1, 32'd1, KIND_SHARED, 64'd0, 64'd0, 64'd0, 1'b0,
		                   1'b1, ST_NOT_FOUND));
		plan.push_back(row(OP_RELEASE_ALL, 32'hFFFF_FFFF, 32'd0, KIND_SHARED, 64'd0, 64'd0, 64'd0,
		                   1'b0, 1'b1, ST_OK));
		plan.push_back(row(OP_ACQUIRE, 32'd1, 32'd5, KIND_BAD_LO, 64'd0, 64'd1, 64'd0, 1'b0,
		                   1'b1, ST_BAD_KIND));
		plan.push_back(row(OP_ACQUIRE, 32'd1, 32'd5, KIND_BAD_HI, 64'd0, 64'd1, 64'd0, 1'b0,
		                   1'b1, ST_BAD_KIND));
		// exclusive lock to end of file, then collide with it at the very last byte
		plan.push_back(row(OP_ACQUIRE, 32'd1, 32'd5, KIND_EXCL, 64'd0, 64'd0, 64'd0, 1'b0,
		                   1'b1, ST_OK));
		plan.push_back(row(OP_ACQUIRE, 32'd2, 32'd5, KIND_SHARED, END_OF_FILE, 64'd1, 64'd0, 1'b0,
		                   1'b1, ST_DENIED));
		plan.push_back(row(OP_CHECK, 32'd0, 32'd5, KIND_SHARED, 64'd0, 64'd0, END_OF_FILE, 1'b0,
		                   1'b1, ST_DENIED));
		// region end saturates
		plan.push_back(row(OP_ACQUIRE, 32'd2, 32'hFFFF_FFFF, KIND_SHARED, END_OF_FILE - 64'd1,
		                   END_OF_FILE, 64'd0, 1'b0, 1'b0, ST_OK));
		plan.push_back(row(OP_CHECK, 32'd0, 32'hFFFF_FFFF, KIND_SHARED, 64'd0, 64'd0, END_OF_FILE,
		                   1'b0, 1'b0, ST_OK));
		plan.push_back(row(OP_CHECK, 32'd0, 32'hFFFF_FFFF, KIND_SHARED, 64'd0, 64'd0, END_OF_FILE,
		                   1'b1, 1'b0, ST_OK));
		plan.push_back(row(OP_CHECK, 32'd0, 32'hFFFF_FFFF, KIND_SHARED, 64'd0, 64'd0,
		                   END_OF_FILE - 64'd2, 1'b1, 1'b0, ST_OK));
		plan.push_back(row(OP_ACQUIRE, 32'd3, 32'hFFFF_FFFF, KIND_SHARED, END_OF_FILE, 64'd1, 64'd0,
		                   1'b0, 1'b0, ST_OK));
		// replace own lock on the same file
		plan.push_back(row(OP_ACQUIRE, 32'd3, 32'hFFFF_FFFF, KIND_EXCL, 64'd0, 64'd1, 64'd0, 1'b0,
		                   1'b0, ST_OK));
		plan.push_back(row(OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_SHARED, 64'd0, 64'd0,
		                   64'd0, 1'b0, 1'b0, ST_OK));
		plan.push_back(row(OP_RELEASE, 32'd3, 32'hFFFF_FFFF, KIND_SHARED, 64'd0, 64'd0, 64'd0, 1'b0,
		                   1'b0, ST_OK));
		plan.push_back(row(OP_RELEASE, 32'd3, 32'hFFFF_FFFF, KIND_SHARED, 64'd0, 64'd0, 64'd0, 1'b0,
		                   1'b0, ST_OK));
		plan.push_back(row(OP_ACQUIRE, 32'd1, 32'd5, KIND_SHARED, 64'd100, 64'd10, 64'd0, 1'b0,
		                   1'b0, ST_OK));
		plan.push_back(row(OP_ACQUIRE, 32'd2, 32'd5, KIND_EXCL, 64'd110, 64'd5, 64'd0, 1'b0,
		                   1'b0, ST_OK));
		plan.push_back(row(OP_ACQUIRE, 32'd2, 32'd5, KIND_EXCL, 64'd109, 64'd1, 64'd0, 1'b0,
		                   1'b0, ST_OK));
		plan.push_back(row(OP_CHECK, 32'd0, 32'd5, KIND_SHARED, 64'd0, 64'd0, 64'd112, 1'b0,
		                   1'b0, ST_OK));
		plan.push_back(row(OP_RELEASE_ALL, 32'd1, 32'd0, KIND_SHARED, 64'd0, 64'd0, 64'd0, 1'b0,
		                   1'b1, ST_OK));
		plan.push_back(row(OP_RELEASE_ALL, 32'd2, 32'd0, KIND_SHARED, 64'd0, 64'd0, 64'd0, 1'b0,
		                   1'b1, ST_OK));
		plan.push_back(row(OP_CHECK, 32'hFFFF_FFFF, 32'd5, KIND_SHARED, 64'd0, 64'd0, 64'd0, 1'b1,
		                   1'b0, ST_OK));

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (plan[k])
			issue(plan[k].req, plan[k].typed, plan[k].want);
		settle();

		foreach (owner_pool[k])
			owner_pool[k] = $urandom;
		foreach (file_pool[k])
			file_pool[k] = $urandom;
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) == 0) begin
				// crowd a fresh file with new owners past capacity, then clear them out
				fill_file = $urandom;
				fill_count = $urandom_range(TABLE_ENTRIES + 1, TABLE_ENTRIES + 4);
				fill_owners.delete();
				repeat (fill_count) begin
					req = random_request();
					req.op = OP_ACQUIRE;
					req.owner = $urandom;
					req.file = fill_file;
					req.kind = KIND_SHARED;
					fill_owners.push_back(req.owner);
					issue(req, 1'b0, ST_OK);
				end
				foreach (fill_owners[k]) begin
					req = random_request();
					req.op = OP_RELEASE_ALL;
					req.owner = fill_owners[k];
					issue(req, 1'b0, ST_OK);
				end
			end else begin
				issue(random_request(), 1'b0, ST_OK);
			end
			if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
				settle();
				paused = 1'b1;
			end
		end
		settle();
		repeat (2 * TABLE_ENTRIES + 8) @(posedge clk);

		if (errors == 0)
			$display("tb_byte_range_lock_table: done, clean");
		else
			$display("tb_byte_range_lock_table: done, errors");
		$finish;
	end

endmodule
